[rtl/roa_pkg.sv]
// ----------------------------------------------------------------------------
// roa_pkg
// Shared constants, request and status codes and the reject table write
// bundle of the resource ownership arbiter.
// ----------------------------------------------------------------------------
package roa_pkg;

  localparam int NUM_MODULES  = 8;
  localparam int REJECT_SLOTS = 8;

  localparam int MOD_IDX_W  = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int SLOT_IDX_W = (REJECT_SLOTS > 1) ? $clog2(REJECT_SLOTS) : 1;
  localparam int SCAN_W     = (MOD_IDX_W > SLOT_IDX_W) ? MOD_IDX_W : SLOT_IDX_W;

  // request types
  localparam logic [3:0] REQ_ACQUIRE   = 4'd0;
  localparam logic [3:0] REQ_RELEASE   = 4'd1;
  localparam logic [3:0] REQ_FORCE     = 4'd2;
  localparam logic [3:0] REQ_DISALLOW  = 4'd3;
  localparam logic [3:0] REQ_SET_STATE = 4'd4;
  localparam logic [3:0] REQ_QUERY     = 4'd5;
  localparam logic [3:0] REQ_GONE      = 4'd6;
  localparam logic [3:0] REQ_RESET     = 4'd7;
  localparam logic [3:0] REQ_POLICY    = 4'd8;

  // acquire status
  localparam logic [1:0] ST_ALLOWED  = 2'd0;
  localparam logic [1:0] ST_IN_USE   = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_ASK      = 2'd3;

  // access modes
  localparam logic [1:0] MODE_ALLOW = 2'd0;
  localparam logic [1:0] MODE_DENY  = 2'd1;
  localparam logic [1:0] MODE_ASK   = 2'd2;

  typedef struct packed {
    logic                   clr_all;
    logic                   we;
    logic [SLOT_IDX_W-1:0]  idx;
    logic [31:0]            client;
    logic [NUM_MODULES-1:0] mods;
  } rej_wr_t;

endpackage

[rtl/roa_rej_tbl.sv]
// ----------------------------------------------------------------------------
// roa_rej_tbl
// Table of refused clients: one valid bit, client id and module mask per
// slot, one write port and one read port.
// ----------------------------------------------------------------------------
module roa_rej_tbl
  import roa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  rej_wr_t                wr,
  input  logic [SLOT_IDX_W-1:0]  rd_idx,
  output logic                   rd_valid,
  output logic [31:0]            rd_client,
  output logic [NUM_MODULES-1:0] rd_mods
);

  logic [REJECT_SLOTS-1:0] slot_valid_r;
  logic [REJECT_SLOTS-1:0] slot_valid_nxt;
  logic [31:0]             client_r [REJECT_SLOTS];
  logic [NUM_MODULES-1:0]  mods_r   [REJECT_SLOTS];

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (wr.clr_all) begin
      slot_valid_nxt = '0;
    end else if (wr.we) begin
      slot_valid_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  // client and mask are only looked at where the slot is valid
  always_ff @(posedge clk) begin
    if (wr.we && !wr.clr_all) begin
      client_r[wr.idx] <= wr.client;
      mods_r[wr.idx]   <= wr.mods;
    end
  end

  assign rd_valid  = slot_valid_r[rd_idx];
  assign rd_client = client_r[rd_idx];
  assign rd_mods   = mods_r[rd_idx];

endmodule

[rtl/resource_ownership_arbiter.sv]
// ----------------------------------------------------------------------------
// resource_ownership_arbiter
// Owner table, busy flags and refused-client table for a fixed set of
// modules; one result transaction per request transaction.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  request  | in_valid / in_stall / in_*     | in
//  result   | out_valid / out_stall / out_*  | out
//  config   | cfg_wr_en / cfg_wr_data        | in
//
//  acquire that reaches the reject check and driver disallow go through the
//  reject scan (one slot of the reject table per cycle) and its finish state,
//  client gone and policy update through the module scan (one module per
//  cycle through the shared id comparator). one request at a time: in_stall
//  stays high from accept until the result transaction completes. reset
//  clears owners, busy flags, rejects and mode.
// ----------------------------------------------------------------------------
module resource_ownership_arbiter
  import roa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic [2:0]  in_module_req,
  input  logic [31:0] in_app_id,
  input  logic        in_app_exists,
  input  logic        in_app_full_focus,
  input  logic        in_busy_value,
  input  logic [7:0]  in_allowed_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_acquire_status,
  output logic        out_ok,
  output logic [7:0]  out_released_mask,
  output logic        out_reject_overflow
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_RSCAN = 3'd2;
  localparam logic [2:0] S_RFIN  = 3'd3;
  localparam logic [2:0] S_MSCAN = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SCAN_W-1:0]      scan_r, scan_nxt;
  logic [1:0]             mode_r;
  logic [1:0]             stat_r, stat_nxt;
  logic                   ok_r, ok_nxt;
  logic [7:0]             rel_r, rel_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   rej_hit_r, rej_hit_nxt;
  logic                   found_r, found_nxt;
  logic [SLOT_IDX_W-1:0]  found_idx_r, found_idx_nxt;
  logic                   free_r, free_nxt;
  logic [SLOT_IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [NUM_MODULES-1:0] owner_valid_r, owner_valid_nxt;
  logic [NUM_MODULES-1:0] busy_r, busy_nxt;
  logic [31:0]            owner_client_r [NUM_MODULES];

  // latched request
  logic [3:0]  req_r;
  logic [2:0]  mod_r;
  logic [31:0] app_r;
  logic        exists_r;
  logic        focus_r;
  logic        busyv_r;
  logic [7:0]  allowed_r;

  logic                   in_acc;
  logic                   mod_legal;
  logic [MOD_IDX_W-1:0]   mod_idx;
  logic [NUM_MODULES-1:0] mod_bit;
  logic [MOD_IDX_W-1:0]   own_ridx;
  logic [31:0]            cmp_a;
  logic                   cmp_eq;
  logic                   own_we;
  logic                   done;
  logic                   hit;
  logic                   keep;
  logic                   scan_last_mod;
  logic                   scan_last_slot;
  logic [31:0]            scan_ext;
  rej_wr_t                rej_wr;
  logic [SLOT_IDX_W-1:0]  rd_idx;
  logic                   rd_valid;
  logic [31:0]            rd_client;
  logic [NUM_MODULES-1:0] rd_mods;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  assign mod_legal = (32'(mod_r) < NUM_MODULES);
  assign mod_idx   = MOD_IDX_W'(mod_r);
  assign mod_bit   = NUM_MODULES'(1) << mod_idx;

  assign scan_ext       = 32'(scan_r);
  assign scan_last_mod  = (scan_r[MOD_IDX_W-1:0] == MOD_IDX_W'(NUM_MODULES - 1));
  assign scan_last_slot = (scan_r[SLOT_IDX_W-1:0] == SLOT_IDX_W'(REJECT_SLOTS - 1));

  // shared client id comparator
  assign own_ridx = (state_r == S_MSCAN) ? scan_r[MOD_IDX_W-1:0] : mod_idx;
  assign rd_idx   = (state_r == S_RFIN) ? found_idx_r : scan_r[SLOT_IDX_W-1:0];
  assign cmp_a    = (state_r == S_RSCAN) ? rd_client : owner_client_r[own_ridx];
  assign cmp_eq   = (cmp_a == app_r);
  assign hit      = rd_valid && cmp_eq;
  assign keep     = (req_r == REQ_POLICY) && (scan_ext < 32'd8) && allowed_r[scan_ext[2:0]];

  roa_rej_tbl u_rej_tbl (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (rej_wr),
    .rd_idx    (rd_idx),
    .rd_valid  (rd_valid),
    .rd_client (rd_client),
    .rd_mods   (rd_mods)
  );

  always_comb begin
    state_nxt       = state_r;
    scan_nxt        = scan_r;
    stat_nxt        = stat_r;
    ok_nxt          = ok_r;
    rel_nxt         = rel_r;
    ovf_nxt         = ovf_r;
    out_valid_nxt   = out_valid_r && out_stall;
    rej_hit_nxt     = rej_hit_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    owner_valid_nxt = owner_valid_r;
    busy_nxt        = busy_r;
    own_we          = 1'b0;
    done            = 1'b0;
    rej_wr          = '0;
    rej_wr.client   = app_r;
    rej_wr.mods     = mod_bit;

    // mode writes other than ask drop every reject
    if (cfg_wr_en && (cfg_wr_data != MODE_ASK)) begin
      rej_wr.clr_all = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt   = S_DISP;
          scan_nxt    = '0;
          stat_nxt    = ST_ALLOWED;
          ok_nxt      = 1'b0;
          rel_nxt     = '0;
          ovf_nxt     = 1'b0;
          rej_hit_nxt = 1'b0;
          found_nxt   = 1'b0;
          free_nxt    = 1'b0;
        end
      end
      S_DISP: begin
        done = 1'b1;
        case (req_r)
          REQ_ACQUIRE: begin
            if (!exists_r || !mod_legal) begin
              stat_nxt = ST_IN_USE;
            end else if (!owner_valid_r[mod_idx]) begin
              owner_valid_nxt[mod_idx] = 1'b1;
              own_we                   = 1'b1;
            end else if (cmp_eq) begin
              stat_nxt = ST_ALLOWED;
            end else if (!focus_r) begin
              stat_nxt = ST_REJECTED;
            end else begin
              done = 1'b0;
            end
          end
          REQ_RELEASE: begin
            if (mod_legal && owner_valid_r[mod_idx] && cmp_eq) begin
              owner_valid_nxt[mod_idx] = 1'b0;
              rel_nxt[mod_r]           = 1'b1;
              ok_nxt                   = 1'b1;
            end
          end
          REQ_FORCE: begin
            if (mod_legal) begin
              owner_valid_nxt[mod_idx] = 1'b1;
              own_we                   = 1'b1;
            end
          end
          REQ_DISALLOW: begin
            if (mod_legal) begin
              done = 1'b0;
            end
          end
          REQ_SET_STATE: begin
            if (mod_legal) begin
              busy_nxt[mod_idx] = busyv_r;
            end
          end
          REQ_QUERY: begin
            ok_nxt = mod_legal ? !busy_r[mod_idx] : 1'b1;
          end
          REQ_GONE, REQ_POLICY: begin
            done      = 1'b0;
            state_nxt = S_MSCAN;
          end
          REQ_RESET: begin
            for (int m = 0; m < NUM_MODULES; m++) begin
              if (m < 8 && owner_valid_r[m]) begin
                rel_nxt[m[2:0]] = 1'b1;
              end
            end
            owner_valid_nxt = '0;
            busy_nxt        = '0;
            rej_wr.clr_all  = 1'b1;
          end
          default: begin
          end
        endcase
        if (done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else if (req_r != REQ_GONE && req_r != REQ_POLICY) begin
          state_nxt = S_RSCAN;
        end
      end
      S_RSCAN: begin
        if (req_r == REQ_ACQUIRE) begin
          if (hit && rd_mods[mod_idx]) begin
            rej_hit_nxt = 1'b1;
          end
        end else begin
          if (hit && !found_r) begin
            found_nxt     = 1'b1;
            found_idx_nxt = scan_r[SLOT_IDX_W-1:0];
          end
          if (!rd_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = scan_r[SLOT_IDX_W-1:0];
          end
        end
        if (scan_last_slot) begin
          state_nxt = S_RFIN;
        end else begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      S_RFIN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (req_r == REQ_ACQUIRE) begin
          if (rej_hit_r) begin
            stat_nxt = ST_REJECTED;
          end else if (mode_r == MODE_ALLOW) begin
            own_we = 1'b1;
          end else if (mode_r == MODE_ASK) begin
            stat_nxt = ST_ASK;
          end else begin
            stat_nxt = ST_IN_USE;
          end
        end else begin
          // existing slot of this client wins over a free one
          if (found_r) begin
            rej_wr.we   = 1'b1;
            rej_wr.idx  = found_idx_r;
            rej_wr.mods = rd_mods | mod_bit;
          end else if (free_r) begin
            rej_wr.we  = 1'b1;
            rej_wr.idx = free_idx_r;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_MSCAN: begin
        if (owner_valid_r[own_ridx] && cmp_eq && !keep) begin
          owner_valid_nxt[own_ridx] = 1'b0;
          if (scan_ext < 32'd8) begin
            rel_nxt[scan_ext[2:0]] = 1'b1;
          end
        end
        if (scan_last_mod) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      scan_r        <= '0;
      mode_r        <= MODE_ALLOW;
      stat_r        <= ST_ALLOWED;
      ok_r          <= 1'b0;
      rel_r         <= '0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      rej_hit_r     <= 1'b0;
      found_r       <= 1'b0;
      found_idx_r   <= '0;
      free_r        <= 1'b0;
      free_idx_r    <= '0;
      owner_valid_r <= '0;
      busy_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      scan_r        <= scan_nxt;
      stat_r        <= stat_nxt;
      ok_r          <= ok_nxt;
      rel_r         <= rel_nxt;
      ovf_r         <= ovf_nxt;
      out_valid_r   <= out_valid_nxt;
      rej_hit_r     <= rej_hit_nxt;
      found_r       <= found_nxt;
      found_idx_r   <= found_idx_nxt;
      free_r        <= free_nxt;
      free_idx_r    <= free_idx_nxt;
      owner_valid_r <= owner_valid_nxt;
      busy_r        <= busy_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r     <= in_req_type;
      mod_r     <= in_module_req;
      app_r     <= in_app_id;
      exists_r  <= in_app_exists;
      focus_r   <= in_app_full_focus;
      busyv_r   <= in_busy_value;
      allowed_r <= in_allowed_mask;
    end
    if (own_we) begin
      owner_client_r[mod_idx] <= app_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_acquire_status  = stat_r;
  assign out_ok              = ok_r;
  assign out_released_mask   = rel_r;
  assign out_reject_overflow = ovf_r;

endmodule

[rtl/roa_checker.sv]
// ----------------------------------------------------------------------------
// roa_checker
// Port-level checks of the resource ownership arbiter, bound to the top.
// ----------------------------------------------------------------------------
module roa_checker
  import roa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_acquire_status,
  input logic        out_ok,
  input logic [7:0]  out_released_mask,
  input logic        out_reject_overflow
);

  // a taken request blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  // nothing taken while a result is pending
  a_stall_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken with result pending");

  // ok only comes from release or query, which carry no acquire status
  a_ok_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_acquire_status == ST_ALLOWED && !out_reject_overflow)
    else $error("ok combined with acquire status or overflow");

  // overflow is a disallow result and frees nothing
  a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reject_overflow |-> out_released_mask == 8'd0 && !out_ok)
    else $error("overflow combined with release");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_released_mask))
    else $error("stalled result changed");

endmodule

bind resource_ownership_arbiter roa_checker u_roa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_acquire_status  (out_acquire_status),
  .out_ok              (out_ok),
  .out_released_mask   (out_released_mask),
  .out_reject_overflow (out_reject_overflow)
);

[tb/sv/roa_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// roa_scoreboard_pkg
// Request and result types of the arbiter test, and a scoreboard that tracks
// owners, busy flags, refused clients and the access mode to predict the
// result of every accepted request and check the results in order.
// ----------------------------------------------------------------------------
package roa_scoreboard_pkg;

  import roa_pkg::*;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [2:0]  module_req;
    logic [31:0] app_id;
    logic        app_exists;
    logic        app_full_focus;
    logic        busy_value;
    logic [7:0]  allowed_mask;
  } request_t;

  typedef struct packed {
    logic [1:0] acquire_status;
    logic       ok;
    logic [7:0] released_mask;
    logic       reject_overflow;
  } result_t;

  class ownership_scoreboard;

    logic [1:0]             mode_now;
    bit                     owned       [NUM_MODULES];
    logic [31:0]            owner_id    [NUM_MODULES];
    bit                     busy        [NUM_MODULES];
    bit                     slot_used   [REJECT_SLOTS];
    logic [31:0]            slot_client [REJECT_SLOTS];
    logic [NUM_MODULES-1:0] slot_mods   [REJECT_SLOTS];
    result_t                expected_results[$];
    int                     errors;

    function new();
      errors   = 0;
      mode_now = MODE_ALLOW;
      clear_owners();
      clear_rejects();
    endfunction

    function void clear_owners();
      for (int m = 0; m < NUM_MODULES; m++) begin
        owned[m]    = 1'b0;
        owner_id[m] = '0;
        busy[m]     = 1'b0;
      end
    endfunction

    function void clear_rejects();
      for (int s = 0; s < REJECT_SLOTS; s++) begin
        slot_used[s]   = 1'b0;
        slot_client[s] = '0;
        slot_mods[s]   = '0;
      end
    endfunction

    function bit is_refused(logic [31:0] id, int m);
      for (int s = 0; s < REJECT_SLOTS; s++) begin
        if (slot_used[s] && slot_client[s] == id && slot_mods[s][m]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // frees a module; only the low eight modules show in released_mask
    function logic [7:0] freed_bit(int m);
      owned[m] = 1'b0;
      return (m < 8) ? 8'(1 << m) : 8'h00;
    endfunction

    function void apply_mode(logic [1:0] v);
      if (v != MODE_ASK) clear_rejects();
      mode_now = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(request_t r);
      result_t want;
      int      m;
      bit      mod_legal;
      bit      keep;
      bit      placed;
      want      = '0;
      m         = r.module_req;
      mod_legal = (m < NUM_MODULES);
      case (r.req_type)
        REQ_ACQUIRE: begin
          if (!r.app_exists || !mod_legal) begin
            want.acquire_status = ST_IN_USE;
          end else if (!owned[m]) begin
            owned[m]    = 1'b1;
            owner_id[m] = r.app_id;
          end else if (owner_id[m] == r.app_id) begin
            want.acquire_status = ST_ALLOWED;
          end else if (is_refused(r.app_id, m) || !r.app_full_focus) begin
            want.acquire_status = ST_REJECTED;
          end else if (mode_now == MODE_ALLOW) begin
            owner_id[m] = r.app_id;
          end else if (mode_now == MODE_ASK) begin
            want.acquire_status = ST_ASK;
          end else begin
            // deny and the unused fourth mode
            want.acquire_status = ST_IN_USE;
          end
        end
        REQ_RELEASE: begin
          if (mod_legal && owned[m] && owner_id[m] == r.app_id) begin
            want.released_mask = freed_bit(m);
            want.ok            = 1'b1;
          end
        end
        REQ_FORCE: begin
          if (mod_legal) begin
            owned[m]    = 1'b1;
            owner_id[m] = r.app_id;
          end
        end
        REQ_DISALLOW: begin
          if (mod_legal) begin
            placed = 1'b0;
            // an existing slot of this client first, then the lowest free one
            for (int s = 0; s < REJECT_SLOTS; s++) begin
              if (!placed && slot_used[s] && slot_client[s] == r.app_id) begin
                slot_mods[s][m] = 1'b1;
                placed          = 1'b1;
              end
            end
            for (int s = 0; s < REJECT_SLOTS; s++) begin
              if (!placed && !slot_used[s]) begin
                slot_used[s]    = 1'b1;
                slot_client[s]  = r.app_id;
                slot_mods[s]    = '0;
                slot_mods[s][m] = 1'b1;
                placed          = 1'b1;
              end
            end
            if (!placed) want.reject_overflow = 1'b1;
          end
        end
        REQ_SET_STATE: begin
          if (mod_legal) busy[m] = r.busy_value;
        end
        REQ_QUERY: begin
          want.ok = mod_legal ? !busy[m] : 1'b1;
        end
        REQ_GONE, REQ_POLICY: begin
          for (int k = 0; k < NUM_MODULES; k++) begin
            keep = (r.req_type == REQ_POLICY) && (k < 8) && r.allowed_mask[k];
            if (owned[k] && owner_id[k] == r.app_id && !keep) begin
              want.released_mask |= freed_bit(k);
            end
          end
        end
        REQ_RESET: begin
          for (int k = 0; k < NUM_MODULES; k++) begin
            if (owned[k]) want.released_mask |= freed_bit(k);
          end
          clear_owners();
          clear_rejects();
        end
        default: begin
        end
      endcase
      expected_results.insert(expected_results.size(), want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("acquire_status", 8'(want.acquire_status), 8'(got.acquire_status));
        compare_field("ok", 8'(want.ok), 8'(got.ok));
        compare_field("released_mask", want.released_mask, got.released_mask);
        compare_field("reject_overflow", 8'(want.reject_overflow),
                      8'(got.reject_overflow));
      end
    endfunction

  endclass

endpackage

[tb/sv/resource_ownership_arbiter_test.sv]
// ----------------------------------------------------------------------------
// resource_ownership_arbiter_test
// Directed requests walk every request type and acquire outcome, one acquire
// under each access mode, then phases of random requests from a small client
// pool run with random idling on both sides, a long result hold-off and a
// full drain. Every result is checked in order against the scoreboard.
// ----------------------------------------------------------------------------
module resource_ownership_arbiter_test;

  timeunit 1ns;
  timeprecision 1ps;

  import roa_pkg::*;
  import roa_scoreboard_pkg::*;

  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = REJECT_SLOTS + 8;
  localparam int TAIL_CYCLES     = 32;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 6;
  localparam int POOL_SIZE       = 12;

  localparam logic [31:0] ID_A = 32'h0000_0000;
  localparam logic [31:0] ID_B = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_C = 32'h1234_5678;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_req_type;
  logic [2:0]  in_module_req;
  logic [31:0] in_app_id;
  logic        in_app_exists;
  logic        in_app_full_focus;
  logic        in_busy_value;
  logic [7:0]  in_allowed_mask;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_acquire_status;
  logic        out_ok;
  logic [7:0]  out_released_mask;
  logic        out_reject_overflow;

  ownership_scoreboard sb = new();

  logic [31:0] client_pool [POOL_SIZE];
  logic [1:0]  phase_mode  [NUM_PHASES] = '{MODE_ASK, MODE_ASK, MODE_ALLOW, MODE_DENY,
                                            2'd3, MODE_ALLOW};
  bit          no_idle   = 1'b0;
  bit          long_hold = 1'b0;

  resource_ownership_arbiter u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_module_req       (in_module_req),
    .in_app_id           (in_app_id),
    .in_app_exists       (in_app_exists),
    .in_app_full_focus   (in_app_full_focus),
    .in_busy_value       (in_busy_value),
    .in_allowed_mask     (in_allowed_mask),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_acquire_status  (out_acquire_status),
    .out_ok              (out_ok),
    .out_released_mask   (out_released_mask),
    .out_reject_overflow (out_reject_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] pick_client();
    if ($urandom_range(0, 99) < 85) return client_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 33)      r.req_type = REQ_ACQUIRE;
    else if (pick < 45) r.req_type = REQ_RELEASE;
    else if (pick < 53) r.req_type = REQ_FORCE;
    else if (pick < 66) r.req_type = REQ_DISALLOW;
    else if (pick < 72) r.req_type = REQ_SET_STATE;
    else if (pick < 78) r.req_type = REQ_QUERY;
    else if (pick < 84) r.req_type = REQ_GONE;
    else if (pick < 85) r.req_type = REQ_RESET;
    else if (pick < 96) r.req_type = REQ_POLICY;
    else                r.req_type = 4'($urandom_range(REQ_POLICY + 1, 4'hF));
    r.module_req     = 3'($urandom);
    r.app_id         = pick_client();
    r.app_exists     = ($urandom_range(0, 9) != 0);
    r.app_full_focus = ($urandom_range(0, 3) != 0);
    r.busy_value     = 1'($urandom);
    r.allowed_mask   = 8'($urandom);
    return r;
  endfunction

  task automatic send_item(request_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type       <= r.req_type;
    in_module_req     <= r.module_req;
    in_app_id         <= r.app_id;
    in_app_exists     <= r.app_exists;
    in_app_full_focus <= r.app_full_focus;
    in_busy_value     <= r.busy_value;
    in_allowed_mask   <= r.allowed_mask;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic issue(logic [3:0] rt, logic [2:0] mi, logic [31:0] id, logic ex,
                       logic fo, logic bv, logic [7:0] am);
    request_t r;
    r = '{rt, mi, id, ex, fo, bv, am};
    send_item(r);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] v);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.apply_mode(v);
  endtask

  // result side: random stall per transaction, one long hold-off on request
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        n         = HOLD_CYCLES;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_acquire_status, out_ok, out_released_mask, out_reject_overflow});
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    request_t r;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= MODE_ALLOW;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_QUERY;
    in_module_req     <= '0;
    in_app_id         <= '0;
    in_app_exists     <= 1'b0;
    in_app_full_focus <= 1'b0;
    in_busy_value     <= 1'b0;
    in_allowed_mask   <= '0;
    client_pool[0] = ID_A;
    client_pool[1] = ID_B;
    client_pool[2] = 32'h8000_0001;
    for (int k = 3; k < POOL_SIZE; k++) client_pool[k] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    write_mode(MODE_ALLOW);
    issue(REQ_QUERY,     3'd0, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd0, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd0, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd0, ID_B, 1'b0, 1'b1, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd0, ID_B, 1'b1, 1'b0, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd0, ID_B, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_RELEASE,   3'd0, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_RELEASE,   3'd0, ID_B, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_FORCE,     3'd7, ID_B, 1'b0, 1'b0, 1'b0, 8'h00);
    issue(REQ_SET_STATE, 3'd7, ID_B, 1'b0, 1'b0, 1'b1, 8'h00);
    issue(REQ_QUERY,     3'd7, ID_C, 1'b0, 1'b0, 1'b0, 8'h00);
    issue(REQ_DISALLOW,  3'd7, ID_C, 1'b0, 1'b0, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd7, ID_C, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd3, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd5, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    issue(REQ_POLICY,    3'd0, ID_A, 1'b0, 1'b0, 1'b0, 8'h08);
    issue(REQ_GONE,      3'd0, ID_A, 1'b0, 1'b0, 1'b0, 8'hFF);
    issue(4'hF,          3'd7, ID_B, 1'b1, 1'b1, 1'b1, 8'hFF);
    issue(REQ_RESET,     3'd0, ID_A, 1'b0, 1'b0, 1'b0, 8'h00);
    issue(REQ_ACQUIRE,   3'd2, ID_A, 1'b1, 1'b1, 1'b0, 8'h00);
    write_mode(MODE_DENY);
    issue(REQ_ACQUIRE,   3'd2, ID_B, 1'b1, 1'b1, 1'b0, 8'h00);
    write_mode(MODE_ASK);
    issue(REQ_ACQUIRE,   3'd2, ID_B, 1'b1, 1'b1, 1'b0, 8'h00);
    write_mode(2'd3);
    issue(REQ_ACQUIRE,   3'd2, ID_B, 1'b1, 1'b1, 1'b0, 8'h00);

    // random phases, one access mode each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(phase_mode[ph]);
      no_idle = (ph == 2);
      if (phase_mode[ph] == MODE_ASK) begin
        // more refused clients than slots, so the table overflows
        for (int j = 0; j < POOL_SIZE - 2; j++) begin
          r          = random_request();
          r.req_type = REQ_DISALLOW;
          r.app_id   = client_pool[j];
          send_item(r);
        end
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 1 && i == 100) long_hold = 1'b1;
        if (ph == 3 && i == 100) wait_for_results();
        send_item(random_request());
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/roa_pkg.sv
rtl/roa_rej_tbl.sv
rtl/resource_ownership_arbiter.sv
rtl/roa_checker.sv
tb/sv/roa_scoreboard_pkg.sv
tb/sv/resource_ownership_arbiter_test.sv
